### design/tiwr_pkg.sv
// ----------------------------------------------------------------------------
// Table interpolator package
// Shared widths, register indexes, range-mode codes and result codes.
// ----------------------------------------------------------------------------
package tiwr_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int POINT_W   = 32;
    localparam int Q_FRAC    = 16;
    localparam int Q_HALF    = 32768;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    localparam logic [CFG_AW-1:0] REG_TABLE_SIZE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RANGE_MODE = 3'd1;
    localparam logic [CFG_AW-1:0] REG_X_LOW      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_X_HIGH     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_Y_LOW      = 3'd4;
    localparam logic [CFG_AW-1:0] REG_Y_HIGH     = 3'd5;
    localparam logic [CFG_AW-1:0] REG_Y_SPAN     = 3'd6;

    localparam logic [2:0] RM_CLAMP_LIN    = 3'd0;
    localparam logic [2:0] RM_EXTRAP_LIN   = 3'd1;
    localparam logic [2:0] RM_WRAP_LIN     = 3'd2;
    localparam logic [2:0] RM_EXTRAP_LIN_B = 3'd3;
    localparam logic [2:0] RM_CLAMP_NEAR   = 3'd4;
    localparam logic [2:0] RM_CLAMP_NEAR_B = 3'd5;
    localparam logic [2:0] RM_WRAP_NEAR    = 3'd6;
    localparam logic [2:0] RM_FREE_NEAR    = 3'd7;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_X_SPAN = 2'd1;
    localparam logic [1:0] ERR_Y_SPAN = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

endpackage

### design/tiwr_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division settling one quotient bit per stage, with a side payload.
// ----------------------------------------------------------------------------
module tiwr_div_pipe #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_div,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [PW-1:0] o_pay
);

    logic [DW-1:0] r_rem   [NW];
    logic [NW-1:0] r_nq    [NW];
    logic [PW-1:0] r_pay   [NW];
    logic          r_valid [NW];
    logic [DW-1:0] n_rem   [NW];
    logic [NW-1:0] n_nq    [NW];

    always_comb begin
        logic [DW-1:0] rem_in;
        logic [NW-1:0] nq_in;
        logic [DW:0]   trial;
        logic          fits;
        for (int k = 0; k < NW; k++) begin
            rem_in   = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k - 1];
            nq_in    = (k == 0) ? i_num : r_nq[(k == 0) ? 0 : k - 1];
            trial    = {rem_in, nq_in[NW-1]};
            fits     = (trial >= {1'b0, i_div});
            n_rem[k] = fits ? DW'(trial - {1'b0, i_div}) : trial[DW-1:0];
            n_nq[k]  = {nq_in[NW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < NW; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay[0] <= i_pay;
            for (int k = 0; k < NW; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
            end
            for (int k = 1; k < NW; k++) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    assign o_valid = r_valid[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_pay   = r_pay[NW-1];

endmodule

### design/tiwr_sat_mul.sv
// ----------------------------------------------------------------------------
// Saturating signed multiplier
// Three-stage multiply from two partial products, limited to +-(2^63-1).
// ----------------------------------------------------------------------------
module tiwr_sat_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32,
    parameter int PW  = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [B_W-1:0] i_b,
    input  logic        [PW-1:0]  i_pay,
    output logic                  o_valid,
    output logic signed [63:0]    o_prod,
    output logic        [PW-1:0]  o_pay
);

    localparam int LO     = A_W / 2;
    localparam int HI     = A_W - LO;
    localparam int FULL_W = (A_W + B_W > 64) ? A_W + B_W : 64;
    localparam logic [FULL_W-1:0] SMAX = FULL_W'({63{1'b1}});

    logic [A_W-1:0]    r1_ma;
    logic [B_W-1:0]    r1_mb;
    logic              r1_neg;
    logic [PW-1:0]     r1_pay;
    logic [LO+B_W-1:0] r2_plo;
    logic [HI+B_W-1:0] r2_phi;
    logic              r2_neg;
    logic [PW-1:0]     r2_pay;
    logic signed [63:0] r3_prod;
    logic [PW-1:0]     r3_pay;
    logic [2:0]        r_valid;

    logic [FULL_W-1:0] full;
    logic [62:0]       mag;

    always_comb begin
        full = (FULL_W'(r2_phi) << LO) + FULL_W'(r2_plo);
        mag  = (full > SMAX) ? {63{1'b1}} : full[62:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ma   <= i_a[A_W-1] ? A_W'(-i_a) : A_W'(i_a);
            r1_mb   <= i_b[B_W-1] ? B_W'(-i_b) : B_W'(i_b);
            r1_neg  <= i_a[A_W-1] ^ i_b[B_W-1];
            r1_pay  <= i_pay;
            r2_plo  <= r1_ma[LO-1:0] * r1_mb;
            r2_phi  <= r1_ma[A_W-1:LO] * r1_mb;
            r2_neg  <= r1_neg;
            r2_pay  <= r1_pay;
            r3_prod <= r2_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            r3_pay  <= r2_pay;
        end
    end

    assign o_valid = r_valid[2];
    assign o_prod  = r3_prod;
    assign o_pay   = r3_pay;

endmodule

### design/tiwr_table.sv
// ----------------------------------------------------------------------------
// Point table
// Two synchronous copies of the graph points, giving two reads per cycle while enabled.
// ----------------------------------------------------------------------------
module tiwr_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic                             i_wr_en,
    input  logic [AW-1:0]                    i_wr_addr,
    input  logic signed [tiwr_pkg::POINT_W-1:0] i_wr_data,
    input  logic [AW-1:0]                    i_rd_addr_l,
    input  logic [AW-1:0]                    i_rd_addr_r,
    output logic signed [tiwr_pkg::POINT_W-1:0] o_rd_l,
    output logic signed [tiwr_pkg::POINT_W-1:0] o_rd_r
);
    import tiwr_pkg::*;

    logic signed [POINT_W-1:0] mem_l [DEPTH];
    logic signed [POINT_W-1:0] mem_r [DEPTH];
    logic signed [POINT_W-1:0] r_rd_l;
    logic signed [POINT_W-1:0] r_rd_r;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_l[i_wr_addr] <= i_wr_data;
            mem_r[i_wr_addr] <= i_wr_data;
        end
        if (i_en) begin
            r_rd_l <= mem_l[i_rd_addr_l];
            r_rd_r <= mem_r[i_rd_addr_r];
        end
    end

    assign o_rd_l = r_rd_l;
    assign o_rd_r = r_rd_r;

endmodule

### design/table_interpolator_with_range_modes_unit.sv
// ----------------------------------------------------------------------------
// Table interpolator with range modes
// Piecewise-linear or nearest-point evaluation of an equally spaced Q16.16 point table.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock while the output is not held
// back, through three restoring dividers which settle one quotient bit per
// stage: position, wrap remainder and output scaling. Loads travel the
// same pipeline and write the point table at the stage where evaluations
// read it, so every evaluation sees exactly the loads accepted before it.
// Loads produce no output. When the output is held back the whole pipeline
// stalls. The user must write configuration only while the unit is empty;
// the unit itself does not enforce this.
module table_interpolator_with_range_modes_unit #(
    parameter int TABLE_DEPTH = tiwr_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = tiwr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tiwr_pkg::CFG_AW-1:0]      i_cfg_index,
    input  logic [tiwr_pkg::CFG_DW-1:0]      i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // point_index [7:0], point_value [39:8], x_value [71:40]
    input  logic [tiwr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode [0]
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // y_value [31:0], error_code [33:32], zero fill [39:34]
    output logic [tiwr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import tiwr_pkg::*;

    localparam int SPW   = $clog2(TABLE_DEPTH);
    localparam int H_W   = 32 + SPW;
    localparam int NUM_W = H_W + Q_FRAC;
    localparam int POS_W = NUM_W + 1;
    localparam int F_W   = POS_W + 1;
    localparam int IW    = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
    localparam int PAY_W = 1 + 8 + POINT_W;
    localparam logic signed [63:0] V_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] V_MIN = -V_MAX - 64'sd1;
    localparam logic signed [63:0] Y_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Y_MIN = -64'sd2147483648;
    localparam logic [62:0] Q_LIM = 63'd1 << 62;

    // Configuration
    logic [8:0]         r_table_size;
    logic [2:0]         r_range_mode;
    logic signed [31:0] r_x_low;
    logic signed [31:0] r_x_high;
    logic signed [31:0] r_y_low;
    logic signed [31:0] r_y_high;
    logic signed [31:0] r_y_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 9'd2;
            r_range_mode <= RM_CLAMP_LIN;
            r_x_low      <= 32'sd0;
            r_x_high     <= 32'sd65536;
            r_y_low      <= 32'sd0;
            r_y_high     <= 32'sd65536;
            r_y_span     <= 32'sd65536;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_TABLE_SIZE: r_table_size <= i_cfg_wr_data[8:0];
                REG_RANGE_MODE: r_range_mode <= i_cfg_wr_data[2:0];
                REG_X_LOW:      r_x_low      <= i_cfg_wr_data;
                REG_X_HIGH:     r_x_high     <= i_cfg_wr_data;
                REG_Y_LOW:      r_y_low      <= i_cfg_wr_data;
                REG_Y_HIGH:     r_y_high     <= i_cfg_wr_data;
                REG_Y_SPAN:     r_y_span     <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic [SPW-1:0]     spaces;
    logic signed [32:0] dx;
    logic [31:0]        dx_mag;
    logic [31:0]        ys_mag;
    logic signed [32:0] dy;
    logic [1:0]         err_code;

    always_comb begin
        if (r_table_size < 9'd2) begin
            spaces = SPW'(1);
        end else if (32'(r_table_size) > TABLE_DEPTH) begin
            spaces = SPW'(TABLE_DEPTH - 1);
        end else begin
            spaces = SPW'(32'(r_table_size) - 32'd1);
        end
        dx     = 33'(r_x_high) - 33'(r_x_low);
        dx_mag = dx[32] ? 32'(-dx) : dx[31:0];
        ys_mag = r_y_span[31] ? 32'(-33'(r_y_span)) : 32'(r_y_span);
        dy     = 33'(r_y_high) - 33'(r_y_low);
        if (dx == 33'sd0) begin
            err_code = ERR_X_SPAN;
        end else if (r_y_span == 32'sd0) begin
            err_code = ERR_Y_SPAN;
        end else begin
            err_code = ERR_OK;
        end
    end

    logic en;
    logic r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // Input register
    logic               r0_valid;
    logic               r0_load;
    logic [7:0]         r0_idx;
    logic signed [31:0] r0_val;
    logic signed [31:0] r0_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_load <= (s_axis_tuser[0] == KIND_LOAD);
            r0_idx  <= s_axis_tdata[7:0];
            r0_val  <= s_axis_tdata[39:8];
            r0_x    <= s_axis_tdata[71:40];
        end
    end

    // Scaled distance from the first point
    logic signed [32:0]    xd;
    logic signed [SPW+33:0] sp_prod;
    logic signed [SPW+33:0] sp_abs;
    logic                  r1_valid;
    logic                  r1_neg;
    logic [H_W-1:0]        r1_mag;
    logic [PAY_W-1:0]      r1_pay;

    always_comb begin
        xd      = 33'(r0_x) - 33'(r_x_low);
        sp_prod = xd * $signed({1'b0, spaces});
        sp_abs  = sp_prod[SPW+33] ? -sp_prod : sp_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_neg <= sp_prod[SPW+33] ^ dx[32];
            r1_mag <= sp_abs[H_W-1:0];
            r1_pay <= {r0_load, r0_idx, r0_val};
        end
    end

    // Position division
    logic             d1_valid;
    logic [NUM_W-1:0] d1_quo;
    logic [31:0]      d1_rem;
    logic [PAY_W:0]   d1_pay;

    tiwr_div_pipe #(
        .NW (NUM_W),
        .DW (32),
        .PW (PAY_W + 1)
    ) u_div_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_valid),
        .i_num   ({r1_mag, 16'b0}),
        .i_div   (dx_mag),
        .i_pay   ({r1_neg, r1_pay}),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_pay   (d1_pay)
    );

    logic signed [POS_W-1:0] q_ext;
    logic signed [POS_W-1:0] pos_floor;
    logic                    r2_valid;
    logic signed [POS_W-1:0] r2_pos;
    logic [PAY_W-1:0]        r2_pay;

    always_comb begin
        q_ext = $signed({1'b0, d1_quo});
        if (d1_pay[PAY_W]) begin
            pos_floor = (d1_rem != 32'd0) ? -(q_ext + POS_W'(1)) : -q_ext;
        end else begin
            pos_floor = q_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pos <= pos_floor;
            r2_pay <= d1_pay[PAY_W-1:0];
        end
    end

    // Wrap remainder of the whole-point part
    logic signed [POS_W-1:0] h_pt;
    logic signed [POS_W-1:0] h_abs;
    logic                    d2_valid;
    logic [H_W-1:0]          d2_quo;
    logic [SPW-1:0]          d2_rem;
    logic [POS_W+PAY_W:0]    d2_pay;

    always_comb begin
        h_pt  = r2_pos >>> Q_FRAC;
        h_abs = h_pt[POS_W-1] ? -h_pt : h_pt;
    end

    tiwr_div_pipe #(
        .NW (H_W),
        .DW (SPW),
        .PW (POS_W + PAY_W + 1)
    ) u_div_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_valid),
        .i_num   (h_abs[H_W-1:0]),
        .i_div   (spaces),
        .i_pay   ({r2_pos, h_pt[POS_W-1], r2_pay}),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_pay   (d2_pay)
    );

    logic signed [POS_W-1:0] d2_pos;
    logic                    d2_hneg;
    logic [SPW-1:0]          m_fix;
    logic signed [POS_W-1:0] wrapped;
    logic signed [POS_W-1:0] period;
    logic signed [POS_W-1:0] pos_sel;
    logic                    r3_valid;
    logic signed [POS_W-1:0] r3_p;
    logic [PAY_W-1:0]        r3_pay;

    always_comb begin
        d2_pos  = d2_pay[POS_W+PAY_W:PAY_W+1];
        d2_hneg = d2_pay[PAY_W];
        m_fix   = (d2_hneg && d2_rem != '0) ? spaces - d2_rem : d2_rem;
        wrapped = $signed(POS_W'({m_fix, d2_pos[15:0]}));
        period  = $signed(POS_W'({spaces, 16'b0}));
        case (r_range_mode)
            RM_CLAMP_LIN, RM_CLAMP_NEAR, RM_CLAMP_NEAR_B: begin
                if (d2_pos < 0) begin
                    pos_sel = '0;
                end else if (d2_pos > period) begin
                    pos_sel = period;
                end else begin
                    pos_sel = d2_pos;
                end
            end
            RM_WRAP_LIN, RM_WRAP_NEAR: pos_sel = wrapped;
            default: pos_sel = d2_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_p   <= pos_sel;
            r3_pay <= d2_pay[PAY_W-1:0];
        end
    end

    // Table addresses and fraction
    logic signed [POS_W:0]   t_round;
    logic signed [POS_W:0]   t_pt;
    logic signed [POS_W:0]   sp_t;
    logic signed [POS_W-1:0] low_raw;
    logic signed [POS_W-1:0] sp_m1;
    logic [SPW-1:0]          near_idx;
    logic [SPW-1:0]          lower;
    logic signed [F_W-1:0]   frac;
    logic                    r4_valid;
    logic                    r4_load;
    logic [7:0]              r4_idx;
    logic signed [31:0]      r4_val;
    logic [SPW-1:0]          r4_addr_l;
    logic [SPW-1:0]          r4_addr_r;
    logic signed [F_W-1:0]   r4_f;
    logic                    r4_near;

    always_comb begin
        t_round = (POS_W+1)'(r3_p) + (POS_W+1)'(Q_HALF);
        t_pt    = t_round >>> Q_FRAC;
        sp_t    = $signed((POS_W+1)'(spaces));
        if (t_round < 0) begin
            near_idx = '0;
        end else if (t_pt > sp_t) begin
            near_idx = spaces;
        end else begin
            near_idx = t_pt[SPW-1:0];
        end
        low_raw = r3_p >>> Q_FRAC;
        sp_m1   = $signed(POS_W'(spaces - 1'b1));
        if (low_raw < 0) begin
            lower = '0;
        end else if (low_raw > sp_m1) begin
            lower = spaces - 1'b1;
        end else begin
            lower = low_raw[SPW-1:0];
        end
        frac = F_W'(r3_p) - $signed(F_W'({lower, 16'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_load   <= r3_pay[PAY_W-1];
            r4_idx    <= r3_pay[PAY_W-2:POINT_W];
            r4_val    <= r3_pay[POINT_W-1:0];
            r4_addr_l <= r_range_mode[2] ? near_idx : lower;
            r4_addr_r <= lower + 1'b1;
            r4_f      <= frac;
            r4_near   <= r_range_mode[2];
        end
    end

    // Point table
    logic               tbl_wr;
    logic signed [31:0] t_l;
    logic signed [31:0] t_r;

    assign tbl_wr = en && r4_valid && r4_load && (32'(r4_idx) < TABLE_DEPTH);

    tiwr_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (SPW)
    ) u_table (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_wr_en     (tbl_wr),
        .i_wr_addr   (SPW'(r4_idx)),
        .i_wr_data   (r4_val),
        .i_rd_addr_l (r4_addr_l),
        .i_rd_addr_r (r4_addr_r),
        .o_rd_l      (t_l),
        .o_rd_r      (t_r)
    );

    logic                  r5_valid;
    logic signed [F_W-1:0] r5_f;
    logic                  r5_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid && !r4_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_f    <= r4_f;
            r5_near <= r4_near;
        end
    end

    // Interpolation between neighbours
    logic               m1_valid;
    logic signed [63:0] m1_prod;
    logic [POINT_W:0]   m1_pay;

    tiwr_sat_mul #(
        .A_W (F_W),
        .B_W (33),
        .PW  (POINT_W + 1)
    ) u_mul_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_valid),
        .i_a     (r5_f),
        .i_b     (33'(t_r) - 33'(t_l)),
        .i_pay   ({t_l, r5_near}),
        .o_valid (m1_valid),
        .o_prod  (m1_prod),
        .o_pay   (m1_pay)
    );

    logic signed [31:0] m1_left;
    logic signed [63:0] lin_sum;
    logic signed [63:0] lin_sat;
    logic               r9_valid;
    logic signed [IW-1:0] r9_inter;

    always_comb begin
        m1_left = m1_pay[POINT_W:1];
        lin_sum = 64'(m1_left) + (m1_prod >>> Q_FRAC);
        if (lin_sum > V_MAX) begin
            lin_sat = V_MAX;
        end else if (lin_sum < V_MIN) begin
            lin_sat = V_MIN;
        end else begin
            lin_sat = lin_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_valid <= 1'b0;
        end else if (en) begin
            r9_valid <= m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_inter <= m1_pay[0] ? IW'(m1_left) : IW'(lin_sat);
        end
    end

    // Output scaling
    logic               m2_valid;
    logic signed [63:0] m2_prod;
    logic [1:0]         m2_err;

    tiwr_sat_mul #(
        .A_W (IW),
        .B_W (33),
        .PW  (2)
    ) u_mul_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_valid),
        .i_a     (r9_inter),
        .i_b     (dy),
        .i_pay   (err_code),
        .o_valid (m2_valid),
        .o_prod  (m2_prod),
        .o_pay   (m2_err)
    );

    logic signed [63:0] p_abs;
    logic               d3_valid;
    logic [62:0]        d3_quo;
    logic [31:0]        d3_rem;
    logic [2:0]         d3_pay;

    assign p_abs = m2_prod[63] ? -m2_prod : m2_prod;

    tiwr_div_pipe #(
        .NW (63),
        .DW (32),
        .PW (3)
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (m2_valid),
        .i_num   (p_abs[62:0]),
        .i_div   (ys_mag),
        .i_pay   ({m2_prod[63] ^ r_y_span[31], m2_err}),
        .o_valid (d3_valid),
        .o_quo   (d3_quo),
        .o_rem   (d3_rem),
        .o_pay   (d3_pay)
    );

    logic [62:0]        q_lim;
    logic               r11_valid;
    logic signed [63:0] r11_q;
    logic [1:0]         r11_err;

    // The remainder is not needed; the truncating quotient is taken, limited to 2^62.
    assign q_lim = (d3_quo > Q_LIM || d3_rem == 32'd0 && d3_quo > Q_LIM) ? Q_LIM : d3_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_valid <= 1'b0;
        end else if (en) begin
            r11_valid <= d3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_q   <= d3_pay[2] ? -$signed({1'b0, q_lim}) : $signed({1'b0, q_lim});
            r11_err <= d3_pay[1:0];
        end
    end

    logic signed [63:0] y_sum;
    logic signed [31:0] y_sat;

    always_comb begin
        y_sum = 64'(r_y_low) + r11_q;
        if (y_sum > Y_MAX) begin
            y_sat = 32'(Y_MAX);
        end else if (y_sum < Y_MIN) begin
            y_sat = 32'(Y_MIN);
        end else begin
            y_sat = 32'(y_sum);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r11_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {6'b0, r11_err, (r11_err != ERR_OK) ? 32'sd0 : y_sat};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
